// ===== sv/tia_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tia_pkg;

	typedef enum logic [3:0] {
		K_ADD = 4'd0, K_SUB = 4'd1, K_MUL = 4'd2, K_DIV = 4'd3, K_MOD = 4'd4,
		K_EQ = 4'd5, K_NEQ = 4'd6, K_LESS = 4'd7, K_GREAT = 4'd8, K_AND = 4'd9,
		K_OR = 4'd10, K_XOR = 4'd11, K_NEG = 4'd12, K_NOT = 4'd13, K_CONV = 4'd14,
		K_BAD = 4'd15
	} kind_t;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_FMT = 2'd1;
	localparam logic [1:0] ERR_DIV0 = 2'd2;

	localparam logic [2:0] FMT_U8 = 3'd0;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	typedef struct packed {
		logic [3:0] kind;
		logic [2:0] dest_format;
		logic [2:0] source_format;
		logic [63:0] left_operand;
		logic [63:0] right_operand;
	} in_t;

	typedef struct packed {
		logic [63:0] result_value;
		logic [1:0] status;
	} out_t;

	// classified operation handed to the back part
	typedef enum logic [1:0] {
		CL_SIMPLE = 2'd0, CL_MUL = 2'd1, CL_DIV = 2'd2
	} cls_t;

	typedef struct packed {
		cls_t cls;
		logic is_mod;
		logic sg;
		logic [63:0] mask;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] simple_r;
		logic [1:0] err;
	} op_t;

	function automatic logic [63:0] fmt_mask(input logic [2:0] f);
		logic [63:0] m;
		begin
			case (f[2:1])
				2'd0: m = 64'hff;
				2'd1: m = 64'hffff;
				2'd2: m = 64'hffff_ffff;
				default: m = '1;
			endcase
			return m;
		end
	endfunction

	function automatic logic [63:0] widen(input logic [63:0] v, input logic [2:0] f);
		logic [63:0] x;
		begin
			case (f[2:1])
				2'd0: x = f[0] ? {{56{v[7]}}, v[7:0]} : {56'd0, v[7:0]};
				2'd1: x = f[0] ? {{48{v[15]}}, v[15:0]} : {48'd0, v[15:0]};
				2'd2: x = f[0] ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
				default: x = v;
			endcase
			return x;
		end
	endfunction

endpackage
`default_nettype wire

// ===== sv/tia_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tia_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire tia_pkg::in_t in_data,
	input wire logic in_valid,
	output logic in_ready,
	output tia_pkg::op_t op_data,
	output logic op_valid,
	input wire logic op_ready
);

	tia_pkg::op_t q_q [tia_pkg::QDEPTH];
	logic [tia_pkg::QPTR_W-1:0] wp_q, rp_q;
	logic [tia_pkg::QPTR_W:0] cnt_q;
	tia_pkg::op_t cls;
	logic [63:0] a, b, ka, kb, r;
	logic sg;
	logic [1:0] err;
	logic push, pop;

	always_comb begin
		sg = in_data.dest_format[0];
		a = tia_pkg::widen(in_data.left_operand, in_data.dest_format);
		b = tia_pkg::widen(in_data.right_operand, in_data.dest_format);
		ka = {a[63] ^ sg, a[62:0]};
		kb = {b[63] ^ sg, b[62:0]};
		r = '0;
		err = tia_pkg::ERR_OK;
		cls.cls = tia_pkg::CL_SIMPLE;
		case (tia_pkg::kind_t'(in_data.kind))
			tia_pkg::K_ADD: r = a + b;
			tia_pkg::K_SUB: r = a - b;
			tia_pkg::K_MUL: cls.cls = tia_pkg::CL_MUL;
			tia_pkg::K_DIV, tia_pkg::K_MOD: begin
				if (b == '0) err = tia_pkg::ERR_DIV0;
				else cls.cls = tia_pkg::CL_DIV;
			end
			tia_pkg::K_EQ: r = {63'd0, ka == kb};
			tia_pkg::K_NEQ: r = {63'd0, ka != kb};
			tia_pkg::K_LESS: r = {63'd0, ka < kb};
			tia_pkg::K_GREAT: r = {63'd0, ka > kb};
			tia_pkg::K_AND: r = a & b;
			tia_pkg::K_OR: r = a | b;
			tia_pkg::K_XOR: r = a ^ b;
			tia_pkg::K_NEG: begin
				if (sg) r = -a;
				else err = tia_pkg::ERR_FMT;
			end
			tia_pkg::K_NOT: begin
				if (in_data.dest_format == tia_pkg::FMT_U8) r = {63'd0, a == '0};
				else err = tia_pkg::ERR_FMT;
			end
			tia_pkg::K_CONV: r = tia_pkg::widen(in_data.left_operand, in_data.source_format);
			default: err = tia_pkg::ERR_FMT;
		endcase
		cls.is_mod = (in_data.kind == tia_pkg::K_MOD);
		cls.sg = sg;
		cls.mask = tia_pkg::fmt_mask(in_data.dest_format);
		cls.a = a;
		cls.b = b;
		cls.simple_r = (err != tia_pkg::ERR_OK) ? '0 : r;
		cls.err = err;
	end

	assign in_ready = (cnt_q != (tia_pkg::QPTR_W+1)'(tia_pkg::QDEPTH));
	assign push = in_valid && in_ready;
	assign op_valid = (cnt_q != '0);
	assign pop = op_valid && op_ready;
	assign op_data = q_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (tia_pkg::QPTR_W+1)'(push) - (tia_pkg::QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= cls;
	end

endmodule
`default_nettype wire

// ===== sv/tia_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// radix-2 restoring divider on magnitudes, one quotient bit per cycle
module tia_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire tia_pkg::op_t op,
	output logic busy,
	output logic [63:0] res
);

	logic [63:0] q_q, rem_q, d_q, mask_q;
	logic [6:0] cnt_q;
	logic neg_q_q, neg_r_q, mod_q;
	logic [65:0] trial;
	logic [64:0] rem_sh;
	logic [63:0] ma, mb, qv, rv;

	always_comb begin
		ma = (op.sg && op.a[63]) ? -op.a : op.a;
		mb = (op.sg && op.b[63]) ? -op.b : op.b;
		rem_sh = {rem_q, q_q[63]};
		trial = {1'b0, rem_sh} - {2'b00, d_q};
		qv = neg_q_q ? -q_q : q_q;
		rv = neg_r_q ? -rem_q : rem_q;
		res = (mod_q ? rv : qv) & mask_q;
	end

	assign busy = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			if (start) cnt_q <= 7'd64;
			else if (busy) cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= ma;
			rem_q <= '0;
			d_q <= mb;
			mask_q <= op.mask;
			mod_q <= op.is_mod;
			neg_q_q <= op.sg && (op.a[63] != op.b[63]);
			neg_r_q <= op.sg && op.a[63];
		end else if (busy) begin
			if (!trial[65]) begin
				rem_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[63:0];
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/tia_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tia_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire tia_pkg::op_t op_data,
	input wire logic op_valid,
	output logic op_ready,
	output tia_pkg::out_t out_data,
	output logic out_valid,
	input wire logic out_ready
);

	// three-stage pipe: s1 partial products, s2 sum, s3 output
	logic v_s1, v_s2;
	logic mul_s1, mul_s2;
	tia_pkg::out_t d_s1, d_s2;
	logic [63:0] mask_s1, mask_s2;
	logic [63:0] p0_s1;
	logic [31:0] p1_s1, p2_s1;
	logic [63:0] prod_s2;
	logic div_busy_q;
	logic div_start, div_busy, div_fin;
	logic [63:0] div_res;
	logic adv, take;

	tia_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .op(op_data),
		.busy(div_busy), .res(div_res)
	);

	// pipe advances when output is free; divider blocks new requests while running
	assign adv = !out_valid || out_ready;
	assign op_ready = adv && !div_busy_q;
	assign take = op_valid && op_ready;
	assign div_start = take && (op_data.cls == tia_pkg::CL_DIV);
	// quotient goes out only after older requests have left the pipe
	assign div_fin = div_busy_q && !div_busy && !v_s1 && !v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
			div_busy_q <= 1'b0;
		end else begin
			if (div_start) div_busy_q <= 1'b1;
			else if (div_fin && adv) div_busy_q <= 1'b0;
			if (adv) begin
				v_s1 <= take && (op_data.cls != tia_pkg::CL_DIV);
				v_s2 <= v_s1;
				out_valid <= v_s2 || div_fin;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s1 <= (op_data.cls == tia_pkg::CL_MUL);
			mask_s1 <= op_data.mask;
			d_s1.result_value <= op_data.simple_r & op_data.mask;
			d_s1.status <= op_data.err;
			p0_s1 <= op_data.a[31:0] * op_data.b[31:0];
			p1_s1 <= op_data.a[63:32] * op_data.b[31:0];
			p2_s1 <= op_data.a[31:0] * op_data.b[63:32];
			mul_s2 <= mul_s1;
			mask_s2 <= mask_s1;
			d_s2 <= d_s1;
			prod_s2 <= p0_s1 + {p1_s1 + p2_s1, 32'd0};
			if (div_fin) begin
				out_data.result_value <= div_res;
				out_data.status <= tia_pkg::ERR_OK;
			end else begin
				out_data.result_value <= mul_s2 ? (prod_s2 & mask_s2) : d_s2.result_value;
				out_data.status <= d_s2.status;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/typed_integer_alu_with_casts_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Typed integer ALU. A front part classifies each request and queues it (two
// entries); the back part runs add, subtract, negate, logic, compare, convert and
// multiply in a three-stage pipeline (s1, s2, output register), one request per
// cycle while the output is not stalled and no divide runs. Divide and modulo use a
// radix-2 divider one bit per cycle, holding off new requests while it runs.
module typed_integer_alu_with_casts_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire tia_pkg::in_t in_data,
	input wire logic in_valid,
	output logic in_ready,
	output tia_pkg::out_t out_data,
	output logic out_valid,
	input wire logic out_ready
);

	tia_pkg::op_t op_data;
	logic op_valid, op_ready;

	tia_front u_front (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .in_valid(in_valid),
		.in_ready(in_ready), .op_data(op_data), .op_valid(op_valid), .op_ready(op_ready)
	);

	tia_back u_back (
		.clk(clk), .arst_n(arst_n), .op_data(op_data), .op_valid(op_valid),
		.op_ready(op_ready), .out_data(out_data), .out_valid(out_valid),
		.out_ready(out_ready)
	);

endmodule
`default_nettype wire
